[rtl/pvc_pkg.sv]
// Shared types and constants for the permutation validity checker.
package pvc_pkg;

  localparam int MAX_LENGTH_DEF = 1024;
  localparam int VALUE_W        = 16;
  localparam int LEN_W          = 11;
  localparam int IDX_W          = 10;
  localparam int EPOCH_W        = 16;
  localparam int QUEUE_DEPTH    = 4;
  localparam int PADDR_W        = 3;
  localparam int PDATA_W        = 32;
  localparam int IN_TDATA_W     = 16;
  localparam int OUT_TDATA_W    = 16;

  localparam logic [PADDR_W-1:0] REG_VECTOR_LENGTH = 3'd0;
  localparam logic [LEN_W-1:0]   LEN_RESET         = 11'd1;

  typedef enum logic [1:0] {
    FAULT_NONE  = 2'd0,
    FAULT_RANGE = 2'd1,
    FAULT_DUP   = 2'd2
  } pvc_fault_t;

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               in_range;
    logic               last;
    logic [IDX_W-1:0]   pos;
  } pvc_item_t;

  localparam int ITEM_W = $bits(pvc_item_t);

endpackage

[rtl/permutation_validity_checker.sv]
// Top level of the permutation validity checker: config register and stream ports.
//
// Elements enter one per cycle while s_tready is high; each is range checked in
// the front end and checked against a seen memory of MAX_LENGTH epoch tags in
// the back end, one read and at most one write of that memory per element. The
// last element leaves the queue once nothing waits ahead of it, passes the
// back-end stage register, and the verdict is offered from the output register
// once that register is free. After reset, and after every 65535 vectors when
// the epoch counter wraps, the back end clears the memory; elements keep
// entering until the 4-entry queue fills, then s_tready drops until the sweep ends.
module permutation_validity_checker #(
  parameter int MAX_LENGTH = pvc_pkg::MAX_LENGTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  input  logic [pvc_pkg::IN_TDATA_W-1:0]    s_tdata,   // [15:0] element_value
  input  logic                              s_tlast,   // last_element
  output logic                              m_tvalid,
  input  logic                              m_tready,
  output logic [pvc_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [0] is_permutation,
                                                       // [2:1] fault_kind,
                                                       // [12:3] fault_position
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [pvc_pkg::PADDR_W-1:0]       paddr,
  input  logic [pvc_pkg::PDATA_W-1:0]       pwdata,
  output logic [pvc_pkg::PDATA_W-1:0]       prdata,
  output logic                              pready
);
  import pvc_pkg::*;

  logic [LEN_W-1:0]   vector_length;
  logic               s_accept;
  logic               q_full;
  logic               q_valid;
  logic               q_pop;
  pvc_item_t          front_item;
  pvc_item_t          head;
  logic [ITEM_W-1:0]  head_bits;
  logic               out_is_perm;
  logic [1:0]         out_kind;
  logic [IDX_W-1:0]   out_pos;

  assign pready   = 1'b1;
  assign prdata   = (paddr == REG_VECTOR_LENGTH) ? PDATA_W'(vector_length) : '0;
  assign s_tready = !q_full;
  assign s_accept = s_tvalid && s_tready;
  assign head     = pvc_item_t'(head_bits);
  assign m_tdata  = {3'b000, out_pos, out_kind, out_is_perm};

  always_ff @(posedge clk) begin
    if (rst) begin
      vector_length <= LEN_RESET;
    end else if (psel && penable && pwrite && pready && paddr == REG_VECTOR_LENGTH) begin
      vector_length <= pwdata[LEN_W-1:0];
    end
  end

  pvc_front u_front (
    .clk           (clk),
    .rst           (rst),
    .value         (s_tdata[VALUE_W-1:0]),
    .last          (s_tlast),
    .accept        (s_accept),
    .vector_length (vector_length),
    .max_length    ((VALUE_W + 1)'(MAX_LENGTH)),
    .item          (front_item)
  );

  pvc_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst   (rst),
    .push  (s_accept),
    .wdata (front_item),
    .full  (q_full),
    .pop   (q_pop),
    .rdata (head_bits),
    .valid (q_valid)
  );

  pvc_back #(
    .MAX_LENGTH (MAX_LENGTH)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .head_valid  (q_valid),
    .pop         (q_pop),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_is_perm (out_is_perm),
    .out_kind    (out_kind),
    .out_pos     (out_pos)
  );

endmodule

[rtl/pvc_front.sv]
// Front end: accepts elements, tags position and range check, feeds the queue.
module pvc_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [pvc_pkg::VALUE_W-1:0]   value,
  input  logic                          last,
  input  logic                          accept,
  input  logic [pvc_pkg::LEN_W-1:0]     vector_length,
  input  logic [pvc_pkg::VALUE_W:0]     max_length,
  output pvc_pkg::pvc_item_t            item
);
  import pvc_pkg::*;

  logic [IDX_W-1:0] index;

  always_comb begin
    item.value    = value;
    item.in_range = (17'(value) < 17'(vector_length)) && (17'(value) < max_length);
    item.last     = last;
    item.pos      = index;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      index <= '0;
    end else if (accept) begin
      if (last) begin
        index <= '0;
      end else begin
        index <= index + 1'b1;
      end
    end
  end

endmodule

[rtl/pvc_fifo.sv]
// Small register queue between front and back ends.
module pvc_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             valid
);
  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;

  assign full  = (count == CW'(DEPTH));
  assign valid = (count != '0);
  assign rdata = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

[rtl/pvc_back.sv]
// Back end: epoch-tagged seen memory, fault tracking and verdict register.
module pvc_back #(
  parameter int MAX_LENGTH = pvc_pkg::MAX_LENGTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  pvc_pkg::pvc_item_t   head,
  input  logic                 head_valid,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 out_is_perm,
  output logic [1:0]           out_kind,
  output logic [pvc_pkg::IDX_W-1:0] out_pos
);
  import pvc_pkg::*;

  localparam int AW = $clog2(MAX_LENGTH);

  logic [EPOCH_W-1:0] tags [MAX_LENGTH];
  logic [EPOCH_W-1:0] tag_rd;
  logic [EPOCH_W-1:0] epoch;
  logic               clearing;
  logic [AW-1:0]      clr_addr;

  logic               b_valid;
  pvc_item_t          b_item;
  logic               b_fwd;
  logic               b_fire;
  logic               b_seen;
  logic               b_write;
  logic [AW-1:0]      b_addr;
  logic [AW-1:0]      head_addr;
  pvc_fault_t         b_kind;
  logic               wrap;
  logic               out_can;

  pvc_fault_t         fault_seen;
  logic [IDX_W-1:0]   first_fault;

  logic               mem_we;
  logic [AW-1:0]      mem_waddr;
  logic [EPOCH_W-1:0] mem_wdata;

  assign b_addr    = b_item.value[AW-1:0];
  assign head_addr = head.value[AW-1:0];
  assign out_can   = !out_valid || out_ready;
  assign b_fire    = b_valid && (!b_item.last || out_can);
  assign b_seen    = b_fwd || (tag_rd == epoch);
  assign b_write   = b_fire && b_item.in_range && !b_seen;
  assign wrap      = b_valid && b_item.last && (epoch == '1);
  assign pop       = head_valid && !clearing && !wrap && (!b_valid || b_fire);

  always_comb begin
    priority if (!b_item.in_range) begin
      b_kind = FAULT_RANGE;
    end else if (b_seen) begin
      b_kind = FAULT_DUP;
    end else begin
      b_kind = FAULT_NONE;
    end
  end

  always_comb begin
    mem_we    = clearing || b_write;
    mem_waddr = clearing ? clr_addr : b_addr;
    mem_wdata = clearing ? '0 : epoch;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      tags[mem_waddr] <= mem_wdata;
    end
    if (pop) begin
      tag_rd <= tags[head_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      b_item <= head;
      b_fwd  <= b_write && !b_item.last && (b_addr == head_addr);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid     <= 1'b0;
      clearing    <= 1'b1;
      clr_addr    <= '0;
      epoch       <= EPOCH_W'(1);
      fault_seen  <= FAULT_NONE;
      first_fault <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (pop) begin
        b_valid <= 1'b1;
      end else if (b_fire) begin
        b_valid <= 1'b0;
      end

      if (clearing) begin
        clr_addr <= clr_addr + 1'b1;
        if (clr_addr == AW'(MAX_LENGTH - 1)) begin
          clearing <= 1'b0;
        end
      end

      if (b_fire) begin
        if (b_item.last) begin
          fault_seen  <= FAULT_NONE;
          first_fault <= '0;
          if (wrap) begin
            clearing <= 1'b1;
            clr_addr <= '0;
            epoch    <= EPOCH_W'(1);
          end else begin
            epoch <= epoch + 1'b1;
          end
        end else if (fault_seen == FAULT_NONE && b_kind != FAULT_NONE) begin
          fault_seen  <= b_kind;
          first_fault <= b_item.pos;
        end
      end

      if (b_fire && b_item.last) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && b_item.last) begin
      if (fault_seen != FAULT_NONE) begin
        out_is_perm <= 1'b0;
        out_kind    <= fault_seen;
        out_pos     <= first_fault;
      end else begin
        out_is_perm <= (b_kind == FAULT_NONE);
        out_kind    <= b_kind;
        out_pos     <= (b_kind == FAULT_NONE) ? '0 : b_item.pos;
      end
    end
  end

endmodule
